@@ rtl/core/assert_macros.svh @@
// shared assertion macros for the orgb blocks
// every user module has clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, quiet while rst is high
`define ORGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that an expression never holds
`define ORGB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/core/orgb_pkg.sv @@
package orgb_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRACTION_BITS = 4;

  // arctangent table depth, iterations past it are not done
  localparam int ATAN_ENTRIES = 24;
  localparam int N_ITER = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int STAGE_W = $clog2(ATAN_ENTRIES);

  localparam int PIX_W = 8;
  localparam int LUMA_W = 12;
  localparam int CHROMA_W = 13;

  localparam int IN_TDATA_W = ((3 * PIX_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = LUMA_W + 2 * CHROMA_W;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

  // cordic datapath: chroma with 16 fraction bits plus gain headroom
  localparam int XY_W = 28;
  // angles, 2^32 units per turn, with room for the left half plane fold
  localparam int ANG_W = 35;

  localparam int C1_SHIFT = 15;
  localparam int COEF_W = 18;
  localparam logic signed [COEF_W-1:0] C2_COEF = COEF_W'(56754);

  localparam logic signed [ANG_W-1:0] ANG_PI = ANG_W'(64'sd2147483648);
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1073741824);
  localparam logic signed [ANG_W-1:0] ANG_THIRD_PI = ANG_W'(64'sd715827883);

  // luma: floor(((299r + 587g + 114b) << F + 500) / 1000)
  localparam int LUMA_K_W = 10;
  localparam logic [LUMA_K_W-1:0] LUMA_KR = LUMA_K_W'(299);
  localparam logic [LUMA_K_W-1:0] LUMA_KG = LUMA_K_W'(587);
  localparam logic [LUMA_K_W-1:0] LUMA_KB = LUMA_K_W'(114);
  localparam logic [LUMA_K_W-1:0] LUMA_BIAS = LUMA_K_W'(500);
  localparam logic [LUMA_K_W-1:0] LUMA_DIV = LUMA_K_W'(1000);
  localparam int SUM_W = 18;
  localparam int LN_W = SUM_W + 1 + FRACTION_BITS;
  // quotient by 1000 loses at least 9 bits
  localparam int Q_W = LN_W - 9;
  localparam int RECIP_SHIFT = 36;
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / LUMA_DIV);
  localparam logic [LUMA_W-1:0] LUMA_MAX = '1;

  // cordic gain compensation, 652032874 / 2^30
  localparam int GAIN_W = 31;
  localparam logic signed [GAIN_W-1:0] INV_GAIN = GAIN_W'(652032874);
  localparam int PROD_W = XY_W + GAIN_W;
  localparam int ROUND_SHIFT = 46 - FRACTION_BITS;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic signed [XY_W-1:0]  c1;
    logic signed [XY_W-1:0]  c2;
    logic [LUMA_W-1:0]       luma;
  } cell_word_t;

  typedef struct packed {
    logic       valid;
    cell_word_t word;
  } cell_bus_t;

  typedef struct packed {
    logic                valid;
    logic [CHROMA_W-1:0] red_green;
    logic [CHROMA_W-1:0] yellow_blue;
    logic [LUMA_W-1:0]   luma;
  } out_bus_t;

  function automatic logic signed [ANG_W-1:0] atan_unit(input logic [STAGE_W-1:0] s);
    logic signed [ANG_W-1:0] a;
    case (s)
      0:  a = ANG_W'(536870912);
      1:  a = ANG_W'(316933406);
      2:  a = ANG_W'(167458907);
      3:  a = ANG_W'(85004756);
      4:  a = ANG_W'(42667331);
      5:  a = ANG_W'(21354465);
      6:  a = ANG_W'(10679838);
      7:  a = ANG_W'(5340245);
      8:  a = ANG_W'(2670163);
      9:  a = ANG_W'(1335087);
      10: a = ANG_W'(667544);
      11: a = ANG_W'(333772);
      12: a = ANG_W'(166886);
      13: a = ANG_W'(83443);
      14: a = ANG_W'(41722);
      15: a = ANG_W'(20861);
      16: a = ANG_W'(10430);
      17: a = ANG_W'(5215);
      18: a = ANG_W'(2608);
      19: a = ANG_W'(1304);
      20: a = ANG_W'(652);
      21: a = ANG_W'(326);
      22: a = ANG_W'(163);
      23: a = ANG_W'(81);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/orgb_front.sv @@
module orgb_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [orgb_pkg::PIX_W-1:0] red_level,
  input  logic [orgb_pkg::PIX_W-1:0] green_level,
  input  logic [orgb_pkg::PIX_W-1:0] blue_level,
  output orgb_pkg::cell_bus_t        out_bus
);
  import orgb_pkg::*;

  localparam int D1_W = PIX_W + 3;
  localparam int D2_W = PIX_W + 1;
  localparam int PR_W = LN_W + RECIP_W;
  localparam int QX_W = Q_W + LUMA_W;

  // stage 0: chroma axes and the scaled luma sum
  logic signed [D1_W-1:0] d1;
  logic signed [D2_W-1:0] d2;
  logic [SUM_W-1:0]       sum;
  logic                   v0;
  logic signed [XY_W-1:0] c1_0, c2_0;
  logic [LN_W-1:0]        n0;

  // stage 1: reciprocal estimate of n / 1000
  logic [PR_W-1:0]        prod;
  logic                   v1;
  logic signed [XY_W-1:0] c1_1, c2_1;
  logic [LN_W-1:0]        n1;
  logic [Q_W-1:0]         q1;

  // stage 2: quotient fix-up, saturation, left half plane fold
  logic [LN_W-1:0]        rem;
  logic                   corr;
  logic [QX_W-1:0]        q_ext;
  cell_word_t             word_next;
  logic                   v2;
  cell_word_t             w2;

  always_comb begin
    d1 = $signed(D1_W'(red_level)) + $signed(D1_W'(green_level))
       - $signed(D1_W'(blue_level) << 1);
    d2 = $signed(D2_W'(red_level)) - $signed(D2_W'(green_level));
    sum = SUM_W'(red_level) * SUM_W'(LUMA_KR) + SUM_W'(green_level) * SUM_W'(LUMA_KG)
        + SUM_W'(blue_level) * SUM_W'(LUMA_KB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_0 <= XY_W'(d1) <<< C1_SHIFT;
      c2_0 <= XY_W'(XY_W'(d2) * XY_W'(C2_COEF));
      n0   <= (LN_W'(sum) << FRACTION_BITS) + LN_W'(LUMA_BIAS);
    end
  end

  assign prod = PR_W'(n0) * PR_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      c1_1 <= c1_0;
      c2_1 <= c2_0;
      n1   <= n0;
      q1   <= Q_W'(prod >> RECIP_SHIFT);
    end
  end

  always_comb begin
    rem   = n1 - LN_W'(LN_W'(q1) * LN_W'(LUMA_DIV));
    corr  = (rem >= LN_W'(LUMA_DIV));
    q_ext = QX_W'(q1) + QX_W'(corr);

    word_next.c1 = c1_1;
    word_next.c2 = c2_1;
    if (q_ext > QX_W'(LUMA_MAX)) begin
      word_next.luma = LUMA_MAX;
    end else begin
      word_next.luma = q_ext[LUMA_W-1:0];
    end

    // left half plane: turn by pi so the vectoring chain converges
    if (c1_1[XY_W-1]) begin
      word_next.x = -c1_1;
      word_next.y = -c2_1;
      word_next.z = c2_1[XY_W-1] ? -ANG_PI : ANG_PI;
    end else begin
      word_next.x = c1_1;
      word_next.y = c2_1;
      word_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w2 <= word_next;
    end
  end

  assign out_bus = '{valid: v2, word: w2};

endmodule

@@ rtl/core/orgb_cordic_cell.sv @@
`include "assert_macros.svh"

module orgb_cordic_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         rot_mode,
  input  logic [orgb_pkg::STAGE_W-1:0] stage,
  input  orgb_pkg::cell_bus_t          in_bus,
  output orgb_pkg::cell_bus_t          out_bus
);
  import orgb_pkg::*;

  logic signed [XY_W-1:0]  x_in, y_in, dx, dy;
  logic signed [ANG_W-1:0] z_in, step_ang;
  logic                    turn_pos;
  cell_word_t              word_next;
  logic                    valid_q;
  cell_word_t              word_q;

  always_comb begin
    x_in     = in_bus.word.x;
    y_in     = in_bus.word.y;
    z_in     = in_bus.word.z;
    dx       = y_in >>> stage;
    dy       = x_in >>> stage;
    step_ang = atan_unit(stage);
    // rotation follows the residual angle, vectoring drives y to zero
    turn_pos = rot_mode ? !z_in[ANG_W-1] : y_in[XY_W-1];

    word_next = in_bus.word;
    if (turn_pos) begin
      word_next.x = x_in - dx;
      word_next.y = y_in + dy;
      word_next.z = z_in - step_ang;
    end else begin
      word_next.x = x_in + dx;
      word_next.y = y_in - dy;
      word_next.z = z_in + step_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_q <= word_next;
    end
  end

  assign out_bus = '{valid: valid_q, word: word_q};

  // after the half plane fold x only grows in vectoring
  `ORGB_NEVER(a_vec_x_neg, valid_q && !rot_mode && word_q.x[XY_W-1], "vectoring x went negative")

endmodule

@@ rtl/core/orgb_angle_map.sv @@
`include "assert_macros.svh"

module orgb_angle_map (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  orgb_pkg::cell_bus_t in_bus,
  output orgb_pkg::cell_bus_t out_bus
);
  import orgb_pkg::*;

  localparam int TRI_W = ANG_W + 2;
  localparam logic [TRI_W-1:0] HALF_U = TRI_W'(ANG_HALF_PI);
  localparam logic [TRI_W-1:0] THIRD_U = TRI_W'(ANG_THIRD_PI);
  localparam logic [TRI_W-1:0] THIRD_X3 = TRI_W'(THIRD_U * 3);

  // stage 1: magnitude of theta
  logic                    v1, neg1;
  logic [ANG_W-1:0]        mag1;
  cell_word_t              w1;
  // stage 2: mapped magnitude
  logic [TRI_W-1:0]        tri_mag, lo, hi;
  logic                    v2, neg2;
  logic signed [ANG_W-1:0] mapped2;
  cell_word_t              w2;
  // stage 3: rotation angle and restart from the raw chroma pair
  logic signed [ANG_W-1:0] rot;
  cell_word_t              word_next;
  logic                    v3;
  cell_word_t              w3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_bus.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1   <= in_bus.word;
      neg1 <= in_bus.word.z[ANG_W-1];
      mag1 <= in_bus.word.z[ANG_W-1] ? ANG_W'(-in_bus.word.z) : ANG_W'(in_bus.word.z);
    end
  end

  always_comb begin
    tri_mag = TRI_W'(mag1) + (TRI_W'(mag1) << 1);
    lo      = tri_mag >> 1;
    hi      = HALF_U + ((tri_mag - THIRD_X3) >> 2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w2      <= w1;
      neg2    <= neg1;
      mapped2 <= $signed(ANG_W'((TRI_W'(mag1) < THIRD_U) ? lo : hi));
    end
  end

  always_comb begin
    rot = neg2 ? -(mapped2 + w2.z) : (mapped2 - w2.z);
    word_next   = w2;
    word_next.x = w2.c1;
    word_next.y = w2.c2;
    word_next.z = rot;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w3 <= word_next;
    end
  end

  assign out_bus = '{valid: v3, word: w3};

  // the correction angle always stays inside a quarter turn
  `ORGB_ASSERT(a_rot_range, v3 |-> (w3.z < ANG_HALF_PI) && (w3.z > -ANG_HALF_PI), "rotation angle out of range")

endmodule

@@ rtl/core/orgb_finish.sv @@
module orgb_finish (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  orgb_pkg::cell_bus_t in_bus,
  output orgb_pkg::out_bus_t  out_bus
);
  import orgb_pkg::*;

  localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'sd1 <<< (ROUND_SHIFT - 1));
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((64'sd1 <<< (CHROMA_W - 1)) - 1);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-(64'sd1 <<< (CHROMA_W - 1)));

  logic                     v1, v2;
  logic signed [PROD_W-1:0] px1, py1;
  logic [LUMA_W-1:0]        luma1, luma2;
  logic [CHROMA_W-1:0]      yb2, rg2;

  function automatic logic [CHROMA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] sh;
    sh = (p + ROUND_BIAS) >>> ROUND_SHIFT;
    if (sh > SAT_HI) begin
      return CHROMA_W'(SAT_HI);
    end else if (sh < SAT_LO) begin
      return CHROMA_W'(SAT_LO);
    end
    return sh[CHROMA_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_bus.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1   <= PROD_W'(in_bus.word.x) * PROD_W'(INV_GAIN);
      py1   <= PROD_W'(in_bus.word.y) * PROD_W'(INV_GAIN);
      luma1 <= in_bus.word.luma;
      yb2   <= round_sat(px1);
      rg2   <= round_sat(py1);
      luma2 <= luma1;
    end
  end

  assign out_bus = '{valid: v2, red_green: rg2, yellow_blue: yb2, luma: luma2};

endmodule

@@ rtl/core/orgb_color_converter.sv @@
// rgb to orgb color converter, fully pipelined, one pixel word per clock while not stalled
//
// input stream s_axis: one rgb pixel per word, 8 bits per component
// output stream m_axis: luma (unsigned) and the yellow-blue and red-green
//   chroma (two's complement), all with four fraction bits, chroma saturated
// datapath: luma and the chroma axes, a vectoring cordic chain that finds
//   the hue angle, the angle remap, a rotation cordic chain, gain
//   compensation with rounding; each cordic iteration is one cell
// path to tvalid: the front registers, each vectoring cell, the angle map, each
//   rotation cell, the finishing registers, then the output register
// throughput: one word per cycle while the receiver keeps up, any mix of pixels
// stall: the output register is backed by a one-word skid buffer; while the
//   skid holds a word the whole pipeline freezes and s_axis_tready is low,
//   and it comes back once the receiver takes the output word
// reset: rst clears every valid bit, so the pipeline comes up empty;
//   data registers are not cleared
module orgb_color_converter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // red_level [7:0], green_level [15:8], blue_level [23:16]
  input  logic [orgb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // luma [11:0], yellow_blue [24:12], red_green [37:25], zero [39:38]
  output logic [orgb_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import orgb_pkg::*;

  logic                   pipe_en;
  cell_bus_t              vec_bus [N_ITER+1];
  cell_bus_t              rot_bus [N_ITER+1];
  out_bus_t               fin_bus;
  logic [OUT_TDATA_W-1:0] fin_data;

  // output register and skid word
  logic                   out_valid;
  logic [OUT_TDATA_W-1:0] out_data;
  logic                   skid_valid;
  logic [OUT_TDATA_W-1:0] skid_data;

  // the pipeline moves whenever the skid word is free
  assign pipe_en       = !skid_valid;
  assign s_axis_tready = pipe_en;

  orgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (pipe_en),
    .in_valid   (s_axis_tvalid),
    .red_level  (s_axis_tdata[PIX_W-1:0]),
    .green_level(s_axis_tdata[2*PIX_W-1:PIX_W]),
    .blue_level (s_axis_tdata[3*PIX_W-1:2*PIX_W]),
    .out_bus    (vec_bus[0])
  );

  // vectoring chain: hue angle of (c1, c2) accumulates in z
  for (genvar i = 0; i < N_ITER; i++) begin : g_vec
    orgb_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (pipe_en),
      .rot_mode(1'b0),
      .stage   (STAGE_W'(i)),
      .in_bus  (vec_bus[i]),
      .out_bus (vec_bus[i+1])
    );
  end

  // theta to theta0 - theta, then restart from the raw chroma pair
  orgb_angle_map u_map (
    .clk    (clk),
    .rst    (rst),
    .en     (pipe_en),
    .in_bus (vec_bus[N_ITER]),
    .out_bus(rot_bus[0])
  );

  // rotation chain: turn (c1, c2) by the correction angle
  for (genvar i = 0; i < N_ITER; i++) begin : g_rot
    orgb_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (pipe_en),
      .rot_mode(1'b1),
      .stage   (STAGE_W'(i)),
      .in_bus  (rot_bus[i]),
      .out_bus (rot_bus[i+1])
    );
  end

  // gain compensation, rounding and saturation
  orgb_finish u_finish (
    .clk    (clk),
    .rst    (rst),
    .en     (pipe_en),
    .in_bus (rot_bus[N_ITER]),
    .out_bus(fin_bus)
  );

  assign fin_data = {OUT_PAD_W'(0), fin_bus.red_green, fin_bus.yellow_blue, fin_bus.luma};

  // output handshake: the skid word drains first, a stalled output parks
  // the finishing word in the skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= fin_bus.valid;
      end
    end else if (pipe_en && fin_bus.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : fin_data;
    end
    if (out_valid && !m_axis_tready && pipe_en) begin
      skid_data <= fin_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // skid only fills behind a held output word
  `ORGB_ASSERT(a_skid_fill, $rose(skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready), "skid filled without a stall")
  `ORGB_NEVER(a_skid_alone, skid_valid && !out_valid, "skid word held with empty output")

endmodule

@@ bench/orgb_color_converter_test.sv @@
`timescale 1ns / 100ps

module orgb_color_converter_test;

  import orgb_pkg::*;

  localparam int RANDOM_PIXELS = 1930;
  // the last pixels of the run go through with no stalls on either side
  localparam int CALM_PIXELS = 300;
  localparam int PIPE_DEPTH = 2 * N_ITER + 8;
  localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH + 20;
  localparam int IDLE_LIMIT = 4000;

  // angle units, 2^32 per turn
  localparam longint TURN_HALF = 64'sd2147483648;
  localparam longint TURN_QUARTER = 64'sd1073741824;
  localparam longint TURN_SIXTH = 64'sd715827883;
  localparam longint RG_SCALE = 64'sd56754;
  localparam longint GAIN_FIX = 64'sd652032874;
  localparam int QSHIFT = 46 - FRACTION_BITS;

  typedef struct packed {
    logic [LUMA_W-1:0]          luma;
    logic signed [CHROMA_W-1:0] yellow_blue;
    logic signed [CHROMA_W-1:0] red_green;
  } orgb_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         known;
    orgb_t      want;
  } pixel_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // arctangent of 2^-i in angle units
  longint hue_step [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // directed pixels: extremes, grays, primaries, both half planes,
  // the pi/3 hue boundary (pure red) and its neighbors
  pixel_row_t pixel_rows [22] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{12'd0,    13'sd0, 13'sd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{12'd4080, 13'sd0, 13'sd0}},
    '{8'd128, 8'd128, 8'd128, 1'b1, '{12'd2048, 13'sd0, 13'sd0}},
    '{8'd127, 8'd127, 8'd127, 1'b1, '{12'd2032, 13'sd0, 13'sd0}},
    '{8'd1,   8'd1,   8'd1,   1'b1, '{12'd16,   13'sd0, 13'sd0}},
    '{8'd255, 8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd255, 1'b0, '0},
    '{8'd255, 8'd255, 8'd0,   1'b0, '0},
    '{8'd0,   8'd255, 8'd255, 1'b0, '0},
    '{8'd255, 8'd0,   8'd255, 1'b0, '0},
    '{8'd1,   8'd0,   8'd0,   1'b0, '0},
    '{8'd0,   8'd1,   8'd0,   1'b0, '0},
    '{8'd0,   8'd0,   8'd1,   1'b0, '0},
    '{8'd10,  8'd0,   8'd200, 1'b0, '0},
    '{8'd0,   8'd10,  8'd200, 1'b0, '0},
    '{8'd200, 8'd100, 8'd0,   1'b0, '0},
    '{8'd255, 8'd1,   8'd0,   1'b0, '0},
    '{8'd255, 8'd0,   8'd1,   1'b0, '0},
    '{8'd170, 8'd85,  8'd255, 1'b0, '0},
    '{8'd85,  8'd170, 8'd255, 1'b0, '0},
    '{8'd254, 8'd1,   8'd128, 1'b0, '0}};

  orgb_t orgb_due [$];

  bit calm = 1'b0;
  int fail_count = 0;
  int pixels_sent = 0;
  int gray_sent = 0;
  int blue_side_sent = 0;
  int results_checked = 0;
  int saturated_seen = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  orgb_color_converter i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // gain compensation, round half up, saturate to the chroma range
  function automatic logic signed [CHROMA_W-1:0] chroma_fix(input longint v);
    longint q;
    q = (v * GAIN_FIX + (longint'(1) <<< (QSHIFT - 1))) >>> QSHIFT;
    if (q > 4095) q = 4095;
    if (q < -4096) q = -4096;
    return q[CHROMA_W-1:0];
  endfunction

  // bit-exact expected orgb triple of one pixel
  function automatic orgb_t orgb_of_pixel(input logic [7:0] r, g, b);
    longint rr, gg, bb, lum, c1, c2, x, y, z, dx, dy, theta, mag, turn;
    int i;
    orgb_t res;
    rr = longint'(r);
    gg = longint'(g);
    bb = longint'(b);
    lum = (((299 * rr + 587 * gg + 114 * bb) <<< FRACTION_BITS) + 500) / 1000;
    if (lum > 4095) lum = 4095;
    // chroma axes with 16 fraction bits
    c1 = ((rr + gg) - 2 * bb) * 32768;
    c2 = (rr - gg) * RG_SCALE;

    // hue angle; fold the left half plane by pi first
    x = c1;
    y = c2;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? TURN_HALF : -TURN_HALF;
      x = -x;
      y = -y;
    end
    for (i = 0; i < N_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += hue_step[i];
      end else begin
        x -= dx;
        y += dy;
        z -= hue_step[i];
      end
    end
    theta = z;

    // stretch below pi/3, compress above, sign kept
    mag = (theta < 0) ? -theta : theta;
    if (mag < TURN_SIXTH) turn = (3 * mag) >>> 1;
    else turn = TURN_QUARTER + ((3 * (mag - TURN_SIXTH)) >>> 2);
    if (theta < 0) turn = -turn;

    // rotate the chroma point by the angle difference
    x = c1;
    y = c2;
    z = turn - theta;
    for (i = 0; i < N_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= hue_step[i];
      end else begin
        x += dx;
        y -= dy;
        z += hue_step[i];
      end
    end

    res.luma = lum[LUMA_W-1:0];
    res.yellow_blue = chroma_fix(x);
    res.red_green = chroma_fix(y);
    return res;
  endfunction

  // offer one pixel word, optionally after an idle burst, and log its result
  task automatic send_pixel(input logic [7:0] r, g, b, input bit known,
                            input orgb_t want);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {b, g, r};
    do @(posedge clk); while (!s_axis_tready);
    orgb_due.insert(orgb_due.size(), known ? want : orgb_of_pixel(r, g, b));
    pixels_sent++;
    if (r == g && g == b) gray_sent++;
    if (2 * int'(b) > int'(r) + int'(g)) blue_side_sent++;
  endtask

  initial begin
    int n, kind, base;
    logic [7:0] r, g, b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (n = 0; n < $size(pixel_rows); n++)
      send_pixel(pixel_rows[n].red, pixel_rows[n].green, pixel_rows[n].blue,
                 pixel_rows[n].known, pixel_rows[n].want);

    for (n = 0; n < RANDOM_PIXELS; n++) begin
      if (n == RANDOM_PIXELS - CALM_PIXELS) calm = 1'b1;
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          // gray of random level
          r = 8'($urandom_range(0, 255));
          g = r;
          b = r;
        end
        1: begin
          // channels pinned at the extremes, the largest chroma values
          r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        end
        2: begin
          // near gray, small chroma and fine hue angles
          base = $urandom_range(3, 252);
          r = 8'(base + $urandom_range(0, 6) - 3);
          g = 8'(base + $urandom_range(0, 6) - 3);
          b = 8'(base + $urandom_range(0, 6) - 3);
        end
        default: begin
          r = 8'($urandom_range(0, 255));
          g = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
      endcase
      send_pixel(r, g, b, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (orgb_due.size() != 0) @(posedge clk);
    // catch any stray word after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d pixels (%0d gray, %0d on the blue side of the hue circle)",
             pixels_sent, gray_sent, blue_side_sent);
    $display("checked %0d output words, %0d chroma values at a saturation bound",
             results_checked, saturated_seen);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // receiver: random stall bursts, none in the calm tail
  always @(posedge clk) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // output word check against the oldest expectation
  always @(posedge clk) begin
    orgb_t got, want;
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.luma = m_axis_tdata[LUMA_W-1:0];
      got.yellow_blue = m_axis_tdata[LUMA_W +: CHROMA_W];
      got.red_green = m_axis_tdata[LUMA_W + CHROMA_W +: CHROMA_W];
      pad = m_axis_tdata[OUT_TDATA_W-1:OUT_FIELDS_W];
      if (pad !== '0) begin
        $error("pad mismatch: expected 0, got %0h", pad);
        fail_count++;
      end
      if (orgb_due.size() == 0) begin
        $error("output word with no pixel pending: luma %0d yellow_blue %0d red_green %0d",
               got.luma, got.yellow_blue, got.red_green);
        fail_count++;
      end else begin
        want = orgb_due.pop_front();
        results_checked++;
        if (want.yellow_blue == 4095 || want.yellow_blue == -4096) saturated_seen++;
        if (want.red_green == 4095 || want.red_green == -4096) saturated_seen++;
        if (got.luma !== want.luma) begin
          $error("luma mismatch: expected %0d, got %0d", want.luma, got.luma);
          fail_count++;
        end
        if (got.yellow_blue !== want.yellow_blue) begin
          $error("yellow_blue mismatch: expected %0d, got %0d",
                 want.yellow_blue, got.yellow_blue);
          fail_count++;
        end
        if (got.red_green !== want.red_green) begin
          $error("red_green mismatch: expected %0d, got %0d",
                 want.red_green, got.red_green);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, orgb_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule
